// ===== sv/gcads_pkg.sv =====
// gcads_pkg: shared constants, types and command codes for the grid cell
// address depth statistics block
// no dependencies
`default_nettype none

package gcads_pkg;

  // active dimensions and coordinate width
  localparam int DIMS      = 4;
  localparam int PORT_DIMS = 4;
  localparam int COORD_W   = 32;

  // field and derived widths
  localparam int SC_W      = 6;
  localparam int LOG_W     = $clog2(COORD_W);
  localparam int CMP_W     = (LOG_W > SC_W) ? LOG_W : SC_W;
  localparam int DEPTH_W   = 8;
  localparam int CNT_W     = 32;
  localparam int SUM_W     = 40;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = SC_W;

  typedef logic [SC_W-1:0]    split_t;
  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [DEPTH_W-1:0] depth_t;
  typedef logic [CNT_W-1:0]   count_t;
  typedef logic [SUM_W-1:0]   dsum_t;

  // command codes
  localparam logic CMD_CLEAR = 1'b0;
  localparam logic CMD_CELL  = 1'b1;

  // per-dimension lane result
  typedef struct packed {
    logic   inverted;
    split_t contrib;
  } lane_res_t;

  // control to the statistics unit
  typedef struct packed {
    logic fire;
    logic command;
    logic aligned;
  } stats_ctl_t;

endpackage

`default_nettype wire

// ===== sv/gcads_in_if.sv =====
// gcads_in_if: valid/ready channel carrying one cell item
// no dependencies
`default_nettype none

interface gcads_in_if;
  logic                  valid;
  logic                  ready;
  logic                  command;
  logic                  on_grid;
  logic [31:0]           low_d0;
  logic [31:0]           high_d0;
  logic [31:0]           low_d1;
  logic [31:0]           high_d1;
  logic [31:0]           low_d2;
  logic [31:0]           high_d2;
  logic [31:0]           low_d3;
  logic [31:0]           high_d3;

  modport source (
    output valid, command, on_grid,
    output low_d0, high_d0, low_d1, high_d1, low_d2, high_d2, low_d3, high_d3,
    input  ready
  );

  modport sink (
    input  valid, command, on_grid,
    input  low_d0, high_d0, low_d1, high_d1, low_d2, high_d2, low_d3, high_d3,
    output ready
  );
endinterface

`default_nettype wire

// ===== sv/gcads_out_if.sv =====
// gcads_out_if: valid/ready channel carrying one statistics result item
// no dependencies
`default_nettype none

interface gcads_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  cell_depth;
  logic [31:0] total_cells;
  logic [31:0] aligned_cells;
  logic [31:0] unaligned_cells;
  logic [7:0]  deepest;
  logic [39:0] depth_total;

  modport source (
    output valid, cell_depth, total_cells, aligned_cells, unaligned_cells,
    output deepest, depth_total,
    input  ready
  );

  modport sink (
    input  valid, cell_depth, total_cells, aligned_cells, unaligned_cells,
    input  deepest, depth_total,
    output ready
  );
endinterface

`default_nettype wire

// ===== sv/grid_cell_address_depth_stats.sv =====
// grid_cell_address_depth_stats: top level, four dimension lanes, merge and
// statistics unit; depends on gcads_pkg, gcads_in_if, gcads_out_if,
// gcads_lane, gcads_merge and gcads_stats
//
// The block takes one cell item per clock unless the result is stalled and
// returns one result item for each, in order. The per-dimension lanes
// (subtract, power-of-two test, log2 encode) are registered in the first
// stage, and the merge adder plus the counter update form the second, whose
// registers drive the result channel. Sustained rate is one item per cycle
// whenever out_ch.ready is high; a stalled result holds the pipe and in_ch
// ready drops only when both stages are full. The user writes split counts
// on the cfg port while idle (not checked); indexes 4 and up are ignored.
`default_nettype none

module grid_cell_address_depth_stats (
  input  wire                              clk,
  input  wire                              rst_n,
  gcads_in_if.sink                         in_ch,
  gcads_out_if.source                      out_ch,
  input  wire                              cfg_we,
  input  wire [gcads_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [gcads_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import gcads_pkg::*;

  split_t     split_r [PORT_DIMS];
  coord_t     lo_a [PORT_DIMS];
  coord_t     hi_a [PORT_DIMS];
  lane_res_t  lane_res [DIMS];
  lane_res_t  lane_r [DIMS];
  logic       s1_valid_r;
  logic       s1_cmd_r;
  logic       s1_aligned_r;
  logic       out_valid_r;
  logic       out_free;
  logic       s1_adv;
  logic       in_fire;
  depth_t     depth;
  stats_ctl_t ctl;

  // split count registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int d = 0; d < PORT_DIMS; d++) begin
        split_r[d] <= '0;
      end
    end else if (cfg_we && (32'(cfg_index) < PORT_DIMS)) begin
      split_r[cfg_index[$clog2(PORT_DIMS)-1:0]] <= cfg_data;
    end
  end

  // coordinates as arrays
  assign lo_a[0] = in_ch.low_d0;
  assign hi_a[0] = in_ch.high_d0;
  assign lo_a[1] = in_ch.low_d1;
  assign hi_a[1] = in_ch.high_d1;
  assign lo_a[2] = in_ch.low_d2;
  assign hi_a[2] = in_ch.high_d2;
  assign lo_a[3] = in_ch.low_d3;
  assign hi_a[3] = in_ch.high_d3;

  // one lane per active dimension
  for (genvar d = 0; d < DIMS; d++) begin : g_lane
    gcads_lane u_lane (
      .lo  (lo_a[d]),
      .hi  (hi_a[d]),
      .sc  (split_r[d]),
      .res (lane_res[d])
    );
  end

  // pipeline handshake
  assign out_free    = !out_valid_r || out_ch.ready;
  assign s1_adv      = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || out_free;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // lane stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r     <= in_ch.command;
      s1_aligned_r <= in_ch.on_grid;
      for (int d = 0; d < DIMS; d++) begin
        lane_r[d] <= lane_res[d];
      end
    end
  end

  // merge lanes into the depth
  gcads_merge u_merge (
    .lanes (lane_r),
    .depth (depth)
  );

  // statistics and result registers
  assign ctl.fire    = s1_adv;
  assign ctl.command = s1_cmd_r;
  assign ctl.aligned = s1_aligned_r;

  gcads_stats u_stats (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .depth      (depth),
    .addr_depth (out_ch.cell_depth),
    .total      (out_ch.total_cells),
    .aligned    (out_ch.aligned_cells),
    .unaligned  (out_ch.unaligned_cells),
    .deepest    (out_ch.deepest),
    .depth_sum  (out_ch.depth_total)
  );

  // result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  assign out_ch.valid = out_valid_r;

endmodule

`default_nettype wire

// ===== sv/gcads_lane.sv =====
// gcads_lane: depth contribution and inverted-range check of one dimension
// depends on gcads_pkg
`default_nettype none

module gcads_lane (
  input  gcads_pkg::coord_t    lo,
  input  gcads_pkg::coord_t    hi,
  input  gcads_pkg::split_t    sc,
  output gcads_pkg::lane_res_t res
);
  import gcads_pkg::*;

  coord_t            span;
  coord_t            span_m1;
  logic              is_pow2;
  logic              lo_aligned;
  logic [LOG_W-1:0]  lg;
  logic [CMP_W-1:0]  sc_ext;
  logic [CMP_W-1:0]  lg_ext;
  split_t            contrib;

  // span and power-of-two tests
  assign span       = hi - lo;
  assign span_m1    = span - COORD_W'(1);
  assign is_pow2    = (span != '0) && ((span & span_m1) == '0);
  assign lo_aligned = ((lo & span_m1) == '0);

  // log2 of a one-hot span: or together the indexes of set bits
  always_comb begin
    lg = '0;
    for (int i = 0; i < COORD_W; i++) begin
      if (span[i]) begin
        lg = lg | LOG_W'(i);
      end
    end
  end

  assign sc_ext = CMP_W'(sc);
  assign lg_ext = CMP_W'(lg);

  // contribution of this dimension
  always_comb begin
    if ((sc == '0) || (span == '0)) begin
      contrib = '0;
    end else if (is_pow2 && lo_aligned) begin
      contrib = (sc_ext > lg_ext) ? SC_W'(sc_ext - lg_ext) : '0;
    end else begin
      contrib = sc;
    end
  end

  assign res.inverted = (hi < lo);
  assign res.contrib  = contrib;

endmodule

`default_nettype wire

// ===== sv/gcads_merge.sv =====
// gcads_merge: combines the lane results into the cell's address depth
// depends on gcads_pkg
`default_nettype none

module gcads_merge (
  input  gcads_pkg::lane_res_t lanes [gcads_pkg::DIMS],
  output gcads_pkg::depth_t    depth
);
  import gcads_pkg::*;

  // sum of contributions, zero when any range is inverted
  always_comb begin
    logic   any_inv;
    depth_t sum;
    any_inv = 1'b0;
    sum     = '0;
    for (int d = 0; d < DIMS; d++) begin
      any_inv = any_inv | lanes[d].inverted;
      sum     = sum + DEPTH_W'(lanes[d].contrib);
    end
    depth = any_inv ? '0 : sum;
  end

endmodule

`default_nettype wire

// ===== sv/gcads_stats.sv =====
// gcads_stats: saturating cell counters, deepest depth and depth sum
// depends on gcads_pkg
`default_nettype none

module gcads_stats (
  input  wire                 clk,
  input  wire                 rst_n,
  input  gcads_pkg::stats_ctl_t ctl,
  input  gcads_pkg::depth_t   depth,
  output gcads_pkg::depth_t   addr_depth,
  output gcads_pkg::count_t   total,
  output gcads_pkg::count_t   aligned,
  output gcads_pkg::count_t   unaligned,
  output gcads_pkg::depth_t   deepest,
  output gcads_pkg::dsum_t    depth_sum
);
  import gcads_pkg::*;

  depth_t addr_depth_r, addr_depth_nxt;
  count_t total_r, total_nxt;
  count_t aligned_r, aligned_nxt;
  count_t unaligned_r, unaligned_nxt;
  depth_t deepest_r, deepest_nxt;
  dsum_t  depth_sum_r, depth_sum_nxt;
  logic [SUM_W:0] sum_wide;

  assign sum_wide = {1'b0, depth_sum_r} + (SUM_W + 1)'(depth);

  // next counter values for one item
  always_comb begin
    addr_depth_nxt = addr_depth_r;
    total_nxt      = total_r;
    aligned_nxt    = aligned_r;
    unaligned_nxt  = unaligned_r;
    deepest_nxt    = deepest_r;
    depth_sum_nxt  = depth_sum_r;
    if (ctl.fire) begin
      addr_depth_nxt = '0;
      if (ctl.command == CMD_CLEAR) begin
        total_nxt     = '0;
        aligned_nxt   = '0;
        unaligned_nxt = '0;
        deepest_nxt   = '0;
        depth_sum_nxt = '0;
      end else begin
        total_nxt = (&total_r) ? total_r : total_r + CNT_W'(1);
        if (ctl.aligned) begin
          addr_depth_nxt = depth;
          aligned_nxt    = (&aligned_r) ? aligned_r : aligned_r + CNT_W'(1);
          deepest_nxt    = (depth > deepest_r) ? depth : deepest_r;
          depth_sum_nxt  = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
        end else begin
          unaligned_nxt = (&unaligned_r) ? unaligned_r : unaligned_r + CNT_W'(1);
        end
      end
    end
  end

  // counter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_depth_r <= '0;
      total_r      <= '0;
      aligned_r    <= '0;
      unaligned_r  <= '0;
      deepest_r    <= '0;
      depth_sum_r  <= '0;
    end else begin
      addr_depth_r <= addr_depth_nxt;
      total_r      <= total_nxt;
      aligned_r    <= aligned_nxt;
      unaligned_r  <= unaligned_nxt;
      deepest_r    <= deepest_nxt;
      depth_sum_r  <= depth_sum_nxt;
    end
  end

  assign addr_depth = addr_depth_r;
  assign total      = total_r;
  assign aligned    = aligned_r;
  assign unaligned  = unaligned_r;
  assign deepest    = deepest_r;
  assign depth_sum  = depth_sum_r;

endmodule

`default_nettype wire
